/* rtl/core/wafd_pkg.sv */
// ----------------------------------------------------------------------------
// wafd_pkg
// Shared types and constants for the weight average and flow detect block.
// ----------------------------------------------------------------------------
package wafd_pkg;

  localparam int unsigned W_W     = 32;  // sample width, Q24.8
  localparam int unsigned SUM_W   = 38;  // window sum, up to 64 samples
  localparam int unsigned CNT_W   = 7;   // fill count, 0..64
  localparam int unsigned RUN_W   = 8;   // consecutive rise count
  localparam int unsigned DIV_CW  = $clog2(SUM_W);
  localparam int unsigned CFG_IW  = 1;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_RISE_THRESHOLD = 1'd0;
  localparam logic [CFG_IW-1:0] REG_RISES_NEEDED   = 1'd1;

  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  localparam logic signed [W_W-1:0] SAT_MAX = {1'b0, {(W_W-1){1'b1}}};
  localparam logic signed [W_W-1:0] SAT_MIN = {1'b1, {(W_W-1){1'b0}}};

  // command codes
  localparam logic [1:0] CMD_SAMPLE   = 2'd0;
  localparam logic [1:0] CMD_FLOW_RST = 2'd1;
  localparam logic [1:0] CMD_FILT_RST = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]            command;
    logic signed [W_W-1:0] weight;
  } in_req_t;

  typedef struct packed {
    logic signed [W_W-1:0] raw_weight;
    logic signed [W_W-1:0] average_weight;
    logic signed [W_W-1:0] rise;
    logic                  flow_detected;
    logic [CNT_W-1:0]      samples_held;
  } out_req_t;

  // controller strobes
  typedef struct packed {
    logic in_ready;
    logic mem_we;
    logic div_start;
    logic out_load;
  } ctl_t;

endpackage

/* rtl/core/wafd_window_mem.sv */
// ----------------------------------------------------------------------------
// wafd_window_mem
// Sample ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wafd_window_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned IDX_W = 3
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [IDX_W-1:0]              waddr,
  input  logic signed [wafd_pkg::W_W-1:0] wdata,
  input  logic [IDX_W-1:0]              raddr,
  output logic signed [wafd_pkg::W_W-1:0] rdata
);

  logic signed [wafd_pkg::W_W-1:0] mem [DEPTH];
  logic signed [wafd_pkg::W_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/wafd_divider.sv */
// ----------------------------------------------------------------------------
// wafd_divider
// Signed sum by small unsigned count, restoring, one quotient bit per cycle.
// Truncates toward zero.
// ----------------------------------------------------------------------------
module wafd_divider (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [wafd_pkg::SUM_W-1:0] dividend,
  input  logic [wafd_pkg::CNT_W-1:0]        divisor,
  output logic                              done,
  output logic signed [wafd_pkg::W_W-1:0]   quotient
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [wafd_pkg::DIV_CW-1:0]       cnt_r, cnt_nxt;
  logic                              neg_r, neg_nxt;
  logic [wafd_pkg::CNT_W-1:0]        div_r, div_nxt;
  logic [wafd_pkg::CNT_W-1:0]        rem_r, rem_nxt;
  logic [wafd_pkg::SUM_W-1:0]        quo_r, quo_nxt;
  logic [wafd_pkg::CNT_W:0]          trial;
  logic [wafd_pkg::CNT_W:0]          diff;
  logic [wafd_pkg::SUM_W-1:0]        q_signed;

  assign trial = {rem_r, quo_r[wafd_pkg::SUM_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = wafd_pkg::DIV_CW'(wafd_pkg::SUM_W - 1);
      neg_nxt  = dividend[wafd_pkg::SUM_W-1];
      div_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = dividend[wafd_pkg::SUM_W-1] ? -dividend : dividend;
    end else if (busy_r) begin
      if (!diff[wafd_pkg::CNT_W]) begin
        rem_nxt = diff[wafd_pkg::CNT_W-1:0];
        quo_nxt = {quo_r[wafd_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[wafd_pkg::CNT_W-1:0];
        quo_nxt = {quo_r[wafd_pkg::SUM_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign q_signed = neg_r ? -quo_r : quo_r;
  assign quotient = q_signed[wafd_pkg::W_W-1:0];
  assign done     = done_r;

endmodule

/* rtl/core/weight_average_and_flow_detect_top.sv */
// ----------------------------------------------------------------------------
// weight_average_and_flow_detect_top
// Boxcar moving average of weight samples with a consecutive-rise detector.
// ----------------------------------------------------------------------------
// Each request carries a command and a signed Q24.8 weight. A sample command
// has its result in the output register after the update state, in which
// the ring read data arrives and sum, ring and rise run are updated, the
// bit-serial divider that forms the average, one step per bit of the sum,
// the divide state taking the quotient and the done state registering it.
// Flow reset, filter reset and the unused command code go straight to the
// done state and register their result there. One request is in work at a
// time; the next one can be taken as soon as the result sits in the output
// register, even if the consumer has not yet taken it. A result still waiting
// in the output register holds back the next one, and with it the input. The
// ring holds WINDOW_DEPTH samples in a small synchronous memory; while it
// fills, the average divides by the count held, afterwards by WINDOW_DEPTH,
// truncating toward zero.
// Configuration writes must come while the block is idle.
// ----------------------------------------------------------------------------
module weight_average_and_flow_detect_top #(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  wafd_pkg::in_req_t                     in_data,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output wafd_pkg::out_req_t                    out_data,
  // configuration
  input  logic                                  cfg_we,
  input  logic [wafd_pkg::CFG_IW-1:0]           cfg_index,
  input  logic [wafd_pkg::W_W-1:0]              cfg_wdata
);

  localparam int unsigned IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [wafd_pkg::CNT_W-1:0] DEPTH_CNT = wafd_pkg::CNT_W'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW_DEPTH - 1);

  // configuration registers
  logic signed [wafd_pkg::W_W-1:0]   thr_r;
  logic [wafd_pkg::RUN_W-1:0]        needed_r;

  // block state
  wafd_pkg::state_t                  state_r, state_nxt;
  wafd_pkg::ctl_t                    ctl;
  logic signed [wafd_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [wafd_pkg::CNT_W-1:0]        fill_r, fill_nxt;
  logic [IDX_W-1:0]                  oldest_r, oldest_nxt;
  logic signed [wafd_pkg::W_W-1:0]   avg_r;
  logic signed [wafd_pkg::W_W-1:0]   prev_r;
  logic [wafd_pkg::RUN_W-1:0]        run_r, run_nxt;

  // per-request work registers
  logic signed [wafd_pkg::W_W-1:0]   w_r;
  logic signed [wafd_pkg::SUM_W-1:0] acc_r;     // sum + new sample
  logic signed [wafd_pkg::W_W:0]     d_r;       // exact 33 bit rise
  logic signed [wafd_pkg::W_W-1:0]   raw_r;
  logic signed [wafd_pkg::W_W-1:0]   rise_r;

  logic                              out_valid_r;
  wafd_pkg::out_req_t                out_data_r;

  logic                              accept;
  logic                              full;
  logic [IDX_W-1:0]                  waddr;
  logic signed [wafd_pkg::W_W-1:0]   old_sample;
  logic signed [wafd_pkg::W_W:0]     d_in;
  logic signed [wafd_pkg::W_W-1:0]   rise_sat;
  logic                              div_done;
  logic signed [wafd_pkg::W_W-1:0]   div_q;

  assign accept = in_valid && ctl.in_ready;
  assign full   = (fill_r == DEPTH_CNT);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wafd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.command == wafd_pkg::CMD_SAMPLE) ?
                      wafd_pkg::ST_UPDATE : wafd_pkg::ST_DONE;
        end
      end
      wafd_pkg::ST_UPDATE: state_nxt = wafd_pkg::ST_DIV;
      wafd_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = wafd_pkg::ST_DONE;
        end
      end
      wafd_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = wafd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wafd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      wafd_pkg::ST_IDLE:   ctl.in_ready  = 1'b1;
      wafd_pkg::ST_UPDATE: begin
        ctl.mem_we    = 1'b1;
        ctl.div_start = 1'b1;
      end
      wafd_pkg::ST_DIV:    ctl = '0;
      wafd_pkg::ST_DONE:   ctl.out_load  = !out_valid_r || out_ready;
      default:             ctl = '0;
    endcase
  end

  // ---------------------------------------------------------------- ring
  // Old entry is read at accept from the oldest slot; it is only used once
  // the ring is full. Only one request is in work, so no forwarding needed.
  assign waddr = full ? oldest_r : fill_r[IDX_W-1:0];

  wafd_window_mem #(
    .DEPTH (WINDOW_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (ctl.mem_we),
    .waddr (waddr),
    .wdata (w_r),
    .raddr (oldest_r),
    .rdata (old_sample)
  );

  wafd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (sum_nxt),
    .divisor  (fill_nxt),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------- datapath
  assign d_in = {in_data.weight[wafd_pkg::W_W-1], in_data.weight} -
                {prev_r[wafd_pkg::W_W-1], prev_r};

  always_comb begin
    if (d_in[wafd_pkg::W_W] != d_in[wafd_pkg::W_W-1]) begin
      rise_sat = d_in[wafd_pkg::W_W] ? wafd_pkg::SAT_MIN : wafd_pkg::SAT_MAX;
    end else begin
      rise_sat = d_in[wafd_pkg::W_W-1:0];
    end
  end

  // window and rise run update in the update state; filter reset clears the window, flow reset the run
  always_comb begin
    sum_nxt    = sum_r;
    fill_nxt   = fill_r;
    oldest_nxt = oldest_r;
    run_nxt    = run_r;
    if (state_r == wafd_pkg::ST_UPDATE) begin
      if (full) begin
        sum_nxt    = acc_r - wafd_pkg::SUM_W'(old_sample);
        oldest_nxt = (oldest_r == LAST_SLOT) ? '0 : oldest_r + 1'b1;
      end else begin
        sum_nxt  = acc_r;
        fill_nxt = fill_r + 1'b1;
      end
      if (d_r > $signed({thr_r[wafd_pkg::W_W-1], thr_r})) begin
        run_nxt = (run_r == wafd_pkg::RUN_MAX) ? run_r : run_r + 1'b1;
      end else begin
        run_nxt = '0;
      end
    end else if (accept) begin
      case (in_data.command)
        wafd_pkg::CMD_FLOW_RST: run_nxt = '0;
        wafd_pkg::CMD_FILT_RST: begin
          sum_nxt    = '0;
          fill_nxt   = '0;
          oldest_nxt = '0;
        end
        default: run_nxt = run_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wafd_pkg::ST_IDLE;
      thr_r       <= wafd_pkg::W_W'(256);
      needed_r    <= wafd_pkg::RUN_W'(3);
      sum_r       <= '0;
      fill_r      <= '0;
      oldest_r    <= '0;
      avg_r       <= '0;
      prev_r      <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sum_r    <= sum_nxt;
      fill_r   <= fill_nxt;
      oldest_r <= oldest_nxt;
      run_r    <= run_nxt;
      if (cfg_we) begin
        case (cfg_index)
          wafd_pkg::REG_RISE_THRESHOLD: thr_r    <= cfg_wdata;
          wafd_pkg::REG_RISES_NEEDED:   needed_r <= cfg_wdata[wafd_pkg::RUN_W-1:0];
          default: ;
        endcase
      end
      if (accept && (in_data.command == wafd_pkg::CMD_SAMPLE ||
                     in_data.command == wafd_pkg::CMD_FLOW_RST)) begin
        prev_r <= in_data.weight;
      end
      if (accept && in_data.command == wafd_pkg::CMD_FILT_RST) begin
        avg_r <= '0;
      end else if (state_r == wafd_pkg::ST_DIV && div_done) begin
        avg_r <= div_q;
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture; raw and rise are zero except where the command sets them
  always_ff @(posedge clk) begin
    if (accept) begin
      w_r    <= in_data.weight;
      acc_r  <= sum_r + wafd_pkg::SUM_W'(in_data.weight);
      d_r    <= d_in;
      raw_r  <= (in_data.command == wafd_pkg::CMD_SAMPLE ||
                 in_data.command == wafd_pkg::CMD_FLOW_RST) ? in_data.weight : '0;
      rise_r <= (in_data.command == wafd_pkg::CMD_SAMPLE) ? rise_sat : '0;
    end
    if (ctl.out_load) begin
      out_data_r.raw_weight     <= raw_r;
      out_data_r.average_weight <= avg_r;
      out_data_r.rise           <= rise_r;
      out_data_r.flow_detected  <= (run_r >= needed_r);
      out_data_r.samples_held   <= fill_r;
    end
  end

  assign in_ready  = ctl.in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // ring never overfills and the oldest pointer stays inside it
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= DEPTH_CNT) && (oldest_r <= LAST_SLOT))
    else $error("fill count or oldest slot out of range");

  // ring only wraps once it is full
  a_wrap_full: assert property (@(posedge clk) disable iff (!rst_n)
    (oldest_r != '0) |-> full)
    else $error("oldest slot moved before ring was full");

  // divider finishes only while the sequencer waits for it
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == wafd_pkg::ST_DIV))
    else $error("divider done outside divide state");

  // a sample request always goes through the ring update next
  a_sample_path: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.command == wafd_pkg::CMD_SAMPLE) |=>
      (state_r == wafd_pkg::ST_UPDATE))
    else $error("sample request skipped ring update");
`endif

endmodule
